/* rtl/lcwu_pkg.sv */
// ----------------------------------------------------------------------------
// lcwu_pkg
// Shared types and constants for the life cell window update block: column
// and result structs, register indexes and the B3/S23 rule thresholds.
// ----------------------------------------------------------------------------
package lcwu_pkg;

  localparam int PIX_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = PIX_W;
  // alive neighbour count of a 3x3 window without its centre fits 0..8
  localparam int CNT_W     = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALIVE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD  = 1'd1;

  // rule thresholds
  localparam logic [CNT_W-1:0] BIRTH_CNT   = 4'd3;
  localparam logic [CNT_W-1:0] SURVIVE_MIN = 4'd2;
  localparam logic [CNT_W-1:0] SURVIVE_MAX = 4'd3;

  // output queue sizing
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t above;
    pix_t centre;
    pix_t below;
  } col_t;

  typedef struct packed {
    pix_t above_pixel;
    pix_t centre_pixel;
    pix_t below_pixel;
    logic row_end;
  } in_item_t;

  typedef struct packed {
    pix_t new_pixel;
    logic last;
  } out_item_t;

  // results handed to the output queue in one cycle
  typedef struct packed {
    logic [1:0] num;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

/* rtl/lcwu_lane.sv */
// ----------------------------------------------------------------------------
// lcwu_lane
// One rule lane: counts alive neighbours in a three-column window and
// returns the next-generation value of the middle column's centre pixel.
// ----------------------------------------------------------------------------
module lcwu_lane import lcwu_pkg::*; (
  input  col_t left_col,
  input  logic left_ok,
  input  col_t mid_col,
  input  col_t right_col,
  input  logic right_ok,
  input  pix_t alive_value,
  input  pix_t dead_value,
  output pix_t new_pixel
);

  logic [2:0]       left_hits;
  logic [2:0]       right_hits;
  logic [1:0]       mid_hits;
  logic [1:0]       left_n;
  logic [1:0]       right_n;
  logic [CNT_W-1:0] nbr_cnt;

  // alive matches per column, edges outside the row count nothing
  assign left_hits  = {left_col.above == alive_value, left_col.centre == alive_value,
                       left_col.below == alive_value} & {3{left_ok}};
  assign right_hits = {right_col.above == alive_value, right_col.centre == alive_value,
                       right_col.below == alive_value} & {3{right_ok}};
  assign mid_hits   = {mid_col.above == alive_value, mid_col.below == alive_value};

  assign left_n  = 2'(left_hits[0]) + 2'(left_hits[1]) + 2'(left_hits[2]);
  assign right_n = 2'(right_hits[0]) + 2'(right_hits[1]) + 2'(right_hits[2]);
  assign nbr_cnt = CNT_W'(left_n) + CNT_W'(right_n)
                 + CNT_W'(mid_hits[0]) + CNT_W'(mid_hits[1]);

  // survival, birth or pass-through; alive test wins when both colours match
  always_comb begin
    new_pixel = mid_col.centre;
    if (mid_col.centre == alive_value) begin
      if (nbr_cnt < SURVIVE_MIN || nbr_cnt > SURVIVE_MAX) begin
        new_pixel = dead_value;
      end
    end else if (mid_col.centre == dead_value) begin
      if (nbr_cnt == BIRTH_CNT) begin
        new_pixel = alive_value;
      end
    end
  end

endmodule

/* rtl/lcwu_outq.sv */
// ----------------------------------------------------------------------------
// lcwu_outq
// Merging output queue: takes up to two lane results per cycle in order and
// hands them out one per transaction on the result channel.
// ----------------------------------------------------------------------------
module lcwu_outq import lcwu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t             entry_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_W-1:0]   count_r, count_nxt;
  logic [OQ_PTR_W-1:0]   wr_ptr_p1;
  logic                  pop;

  // space for a row-end pair is always kept before taking a column
  assign room      = count_r <= OQ_CNT_W'(OQ_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OQ_PTR_W'(push.num);
    rd_ptr_nxt = rd_ptr_r + OQ_PTR_W'(pop);
    count_nxt  = count_r + OQ_CNT_W'(push.num) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, first result at the write pointer, second just after
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      entry_r[wr_ptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      entry_r[wr_ptr_p1] <= push.second;
    end
  end

endmodule

/* rtl/life_cell_window_update_core.sv */
// ----------------------------------------------------------------------------
// life_cell_window_update_core
// B3/S23 life update of a colour-indexed image, one pixel column per
// transaction, with two rule lanes and a merging output queue.
// ----------------------------------------------------------------------------
// Output: with the queue empty, the first result is shown on out_* in the cycle
//   after the column that completes it is accepted; the second result of a
//   row-end pair follows once the first has been taken.
// Throughput: one column per cycle; a row-end column gives two results and
//   the four-entry output queue drains one per cycle, so in_ready drops only
//   under output back-pressure.
// Reset: synchronous rst_n clears the window, the queue and sets
//   alive_value to 1 and dead_value to 0.
module life_cell_window_update_core import lcwu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  pix_t       alive_r, dead_r;
  col_t       left_r, left_nxt;
  col_t       mid_r, mid_nxt;
  logic [1:0] held_r, held_nxt;
  col_t       cur_col;
  logic       accept;
  logic       started;
  col_t       lane0_left, lane0_mid;
  pix_t       lane0_pix, lane1_pix;
  push_t      push;

  assign cur_col = '{above: in_data.above_pixel, centre: in_data.centre_pixel,
                     below: in_data.below_pixel};
  assign accept  = in_valid && in_ready;
  assign started = held_r != 2'd0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= 4'd1;
      dead_r  <= 4'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ALIVE: alive_r <= cfg_wdata;
        REG_DEAD:  dead_r  <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // lane 0: pending pixel, or the lone pixel of a single-column row
  assign lane0_left = left_r;
  assign lane0_mid  = started ? mid_r : cur_col;

  lcwu_lane u_lane0 (
    .left_col    (lane0_left),
    .left_ok     (held_r[1]),
    .mid_col     (lane0_mid),
    .right_col   (cur_col),
    .right_ok    (started),
    .alive_value (alive_r),
    .dead_value  (dead_r),
    .new_pixel   (lane0_pix)
  );

  // lane 1: final pixel of the row, nothing to its right
  lcwu_lane u_lane1 (
    .left_col    (mid_r),
    .left_ok     (1'b1),
    .mid_col     (cur_col),
    .right_col   (cur_col),
    .right_ok    (1'b0),
    .alive_value (alive_r),
    .dead_value  (dead_r),
    .new_pixel   (lane1_pix)
  );

  // merge lane results into queue pushes
  always_comb begin
    push.num    = 2'd0;
    push.first  = '{new_pixel: lane0_pix, last: 1'b0};
    push.second = '{new_pixel: lane1_pix, last: 1'b1};
    if (accept) begin
      if (!started) begin
        if (in_data.row_end) begin
          push.num        = 2'd1;
          push.first.last = 1'b1;
        end
      end else begin
        push.num = in_data.row_end ? 2'd2 : 2'd1;
      end
    end
  end

  // column window update
  always_comb begin
    left_nxt = left_r;
    mid_nxt  = mid_r;
    held_nxt = held_r;
    if (accept) begin
      if (!started) begin
        if (!in_data.row_end) begin
          mid_nxt  = cur_col;
          held_nxt = 2'd1;
        end
      end else if (in_data.row_end) begin
        left_nxt = '0;
        mid_nxt  = '0;
        held_nxt = 2'd0;
      end else begin
        left_nxt = mid_r;
        mid_nxt  = cur_col;
        held_nxt = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      mid_r  <= '0;
      held_r <= 2'd0;
    end else begin
      left_r <= left_nxt;
      mid_r  <= mid_nxt;
      held_r <= held_nxt;
    end
  end

  lcwu_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/lcwu_checker.sv */
// ----------------------------------------------------------------------------
// lcwu_checker
// Port-level checks for the life cell window update core, bound to the top.
// ----------------------------------------------------------------------------
module lcwu_checker import lcwu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // nothing pending straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a row-end column always yields a result on the next cycle
  a_row_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.row_end) |=> out_valid)
    else $error("row-end column gave no result");

  // results appear only from accepted columns
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !(in_valid && in_ready)) |=> !out_valid)
    else $error("result appeared without an input transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind life_cell_window_update_core lcwu_checker u_lcwu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
